FILE: design/ritter_bounding_sphere_core_assert.svh
// assertion macros for the bounding sphere core
`ifndef RITTER_BOUNDING_SPHERE_CORE_ASSERT_SVH
`define RITTER_BOUNDING_SPHERE_CORE_ASSERT_SVH
// implication checked every edge outside reset
`define RBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/rbs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbs_pkg
// shared types and constants of the bounding sphere core
// ---------------------------------------------------------------------------
package rbs_pkg;
  localparam int MAX_POINTS = 4096;
  localparam int CB = 24;
  localparam int RB = CB + 1;
  localparam int AB = $clog2(MAX_POINTS);
  localparam int NB = AB + 1;
  localparam int D2B = 2 * CB + 3;
  localparam int SQB = (D2B + 1) / 2;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEL, ST_SEED, ST_SEEDSQ, ST_RD, ST_DIST, ST_CMP, ST_SQRT,
    ST_DIV, ST_GROW, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [D2B-1:0] val;
  } sqrt_req_t;

  typedef struct packed {
    logic start;
    logic [2*CB+RB:0] num;
    logic [SQB:0] den;
  } div_req_t;
endpackage

FILE: design/rbs_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbs_store
// point memory, one write and one registered read port
// ---------------------------------------------------------------------------
module rbs_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [rbs_pkg::AB-1:0]   waddr,
  input  rbs_pkg::point_t          wdata,
  input  logic                     re,
  input  logic [rbs_pkg::AB-1:0]   raddr,
  output rbs_pkg::point_t          rdata
);
  rbs_pkg::point_t mem [rbs_pkg::MAX_POINTS];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: design/rbs_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbs_sqrt
// bit-serial floor square root, one result bit per cycle
// ---------------------------------------------------------------------------
module rbs_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  rbs_pkg::sqrt_req_t      req,
  output logic                    done,
  output logic [rbs_pkg::SQB-1:0] root
);
  localparam int W = rbs_pkg::D2B + 1;
  logic [W-1:0] rad;
  logic [W+1:0] rem;
  logic [rbs_pkg::SQB-1:0] q;
  logic [$clog2(rbs_pkg::SQB+1)-1:0] cnt;
  logic busy;
  logic [W+1:0] trial;
  logic [W+1:0] rem_sh;

  assign rem_sh = {rem[W-1:0], rad[W-1:W-2]};
  assign trial = rem_sh - {{(W+2-rbs_pkg::SQB-2){1'b0}}, q, 2'b01};
  assign root = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rad <= {1'b0, req.val};
        rem <= '0;
        q <= '0;
        cnt <= '0;
      end else if (busy) begin
        rad <= {rad[W-3:0], 2'b00};
        if (!trial[W+1]) begin
          rem <= trial;
          q <= {q[rbs_pkg::SQB-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          q <= {q[rbs_pkg::SQB-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(rbs_pkg::SQB+1))'(rbs_pkg::SQB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/rbs_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbs_div
// restoring divider, one quotient bit per cycle, floor with remainder flag
// ---------------------------------------------------------------------------
module rbs_div (
  input  logic                clk,
  input  logic                rst,
  input  rbs_pkg::div_req_t   req,
  output logic                done,
  output logic [2*rbs_pkg::CB+rbs_pkg::RB:0] quot,
  output logic                rem_nz
);
  localparam int NW = 2 * rbs_pkg::CB + rbs_pkg::RB + 1;
  localparam int DW = rbs_pkg::SQB + 1;
  logic [NW-1:0] n;
  logic [DW:0] r;
  logic [DW-1:0] d;
  logic [$clog2(NW+1)-1:0] cnt;
  logic busy;
  logic [DW:0] rs;

  assign rs = {r[DW-1:0], n[NW-1]};
  assign quot = n;
  assign rem_nz = |r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        n <= req.num;
        d <= req.den;
        r <= '0;
        cnt <= '0;
      end else if (busy) begin
        if (rs >= {1'b0, d}) begin
          r <= rs - {1'b0, d};
          n <= {n[NW-2:0], 1'b1};
        end else begin
          r <= rs;
          n <= {n[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(NW+1))'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: design/ritter_bounding_sphere_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ritter_bounding_sphere_core
// bounding sphere of a streamed point set, extreme-pair seed then growth pass
// ---------------------------------------------------------------------------
// Points load at one word per cycle into a 4096-entry memory while the six
// axis extremes are tracked. A word with tlast starts the solve: the seed is
// set from the widest extreme pair using the square-root unit, then the growth
// pass reads each stored point through the memory read port (read, distance,
// compare), and every point that grows the sphere takes a square root and a divide
// per axis (shared square root and divider). One result word per set; input is
// held off during the solve and until the result has been taken.
module ritter_bounding_sphere_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // pos_x, pos_y, pos_z
  input  logic         s_tlast,   // last_point
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // center_x, center_y, center_z, sphere_radius, overflowed
  output logic         m_tlast
);
  `include "ritter_bounding_sphere_core_assert.svh"
  localparam int CB = rbs_pkg::CB;
  localparam int AB = rbs_pkg::AB;
  localparam int NB = rbs_pkg::NB;
  localparam int D2B = rbs_pkg::D2B;
  localparam int SQB = rbs_pkg::SQB;
  localparam int NW = 2 * CB + rbs_pkg::RB + 1;

  rbs_pkg::state_t state, state_next;
  rbs_pkg::point_t ext [6];
  rbs_pkg::point_t pin, rd;
  logic [NB-1:0] count, idx;
  logic drop;
  logic signed [CB+1:0] c [3];
  logic [SQB-1:0] r;
  logic [D2B-1:0] d2, best;
  logic [1:0] axis, k;
  logic [SQB-1:0] dval;
  logic signed [CB+1:0] diff [3];
  logic [CB+1:0] adiff [3];
  logic [2*CB+3:0] sq [3];
  rbs_pkg::sqrt_req_t sreq;
  rbs_pkg::div_req_t dreq;
  logic sdone, ddone, rem_nz;
  logic [SQB-1:0] root;
  logic [NW-1:0] quot;
  logic acc, we, re;
  logic [103:0] obuf;

  assign pin = s_tdata;
  assign s_tready = (state == rbs_pkg::ST_LOAD) && !m_tvalid;
  assign acc = s_tvalid && s_tready;
  assign we = acc && (count != NB'(rbs_pkg::MAX_POINTS));
  assign re = (state == rbs_pkg::ST_RD);

  rbs_store u_store (.clk, .we, .waddr(count[AB-1:0]), .wdata(pin),
                     .re, .raddr(idx[AB-1:0]), .rdata(rd));
  rbs_sqrt u_sqrt (.clk, .rst, .req(sreq), .done(sdone), .root);
  rbs_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quot, .rem_nz);

  // squared distance of the operand pair selected by state
  always_comb begin
    rbs_pkg::point_t a, b;
    a = (state == rbs_pkg::ST_SEL) ? ext[{axis, 1'b0}] : rd;
    b = ext[{axis, 1'b1}];
    for (int i = 0; i < 3; i++) begin
      if (state == rbs_pkg::ST_SEL) begin
        diff[i] = (CB+2)'(signed'(b[i*CB +: CB])) - (CB+2)'(signed'(a[i*CB +: CB]));
      end else begin
        diff[i] = (CB+2)'(signed'(a[i*CB +: CB])) - c[i];
      end
      adiff[i] = diff[i][CB+1] ? (CB+2)'(-diff[i]) : (CB+2)'(diff[i]);
      sq[i] = (2*CB+4)'(adiff[i]) * (2*CB+4)'(adiff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sreq = '0;
    dreq = '0;
    case (state)
      rbs_pkg::ST_LOAD: if (acc && s_tlast) state_next = rbs_pkg::ST_SEL;
      rbs_pkg::ST_SEL: if (axis == 2'd2) state_next = rbs_pkg::ST_SEED;
      rbs_pkg::ST_SEED: begin
        sreq.start = 1'b1;
        sreq.val = best;
        state_next = rbs_pkg::ST_SEEDSQ;
      end
      rbs_pkg::ST_SEEDSQ: if (sdone) state_next = rbs_pkg::ST_RD;
      rbs_pkg::ST_RD: state_next = (idx == count) ? rbs_pkg::ST_OUT : rbs_pkg::ST_DIST;
      rbs_pkg::ST_DIST: state_next = rbs_pkg::ST_CMP;
      rbs_pkg::ST_CMP: begin
        if (d2 > D2B'(r * r)) begin
          sreq.start = 1'b1;
          sreq.val = d2;
          state_next = rbs_pkg::ST_SQRT;
        end else begin
          state_next = rbs_pkg::ST_RD;
        end
      end
      rbs_pkg::ST_SQRT: if (sdone) state_next = (root == '0) ? rbs_pkg::ST_RD : rbs_pkg::ST_DIV;
      rbs_pkg::ST_DIV: begin
        dreq.start = 1'b1;
        dreq.num = NW'(adiff[k] * (dval - r));
        dreq.den = {dval, 1'b0};
        state_next = rbs_pkg::ST_GROW;
      end
      rbs_pkg::ST_GROW: begin
        if (ddone) state_next = (k == 2'd2) ? rbs_pkg::ST_RD : rbs_pkg::ST_DIV;
      end
      rbs_pkg::ST_OUT: state_next = rbs_pkg::ST_LOAD;
      default: state_next = rbs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 6; i++) ext[i] <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (acc) begin
        if (we) begin
          count <= count + 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (count == '0 || signed'(pin[i*CB +: CB]) < signed'(ext[2*i][i*CB +: CB]))
              ext[2*i] <= pin;
            if (count == '0 || signed'(pin[i*CB +: CB]) > signed'(ext[2*i+1][i*CB +: CB]))
              ext[2*i+1] <= pin;
          end
        end else begin
          drop <= 1'b1;
        end
      end
      case (state)
        rbs_pkg::ST_LOAD: begin
          axis <= 2'd0;
          best <= '0;
        end
        rbs_pkg::ST_SEL: begin
          if (D2B'(sq[0] + sq[1] + sq[2]) > best) best <= D2B'(sq[0] + sq[1] + sq[2]);
          if (axis != 2'd2) axis <= axis + 1'b1;
        end
        default: ;
      endcase
      if (state == rbs_pkg::ST_OUT) begin
        m_tvalid <= 1'b1;
        count <= '0;
        drop <= 1'b0;
        for (int i = 0; i < 6; i++) ext[i] <= '0;
      end
    end
  end

  // winning axis kept separately because axis is also the scan index
  logic [1:0] win;
  always_ff @(posedge clk) begin
    case (state)
      rbs_pkg::ST_LOAD: win <= 2'd0;
      rbs_pkg::ST_SEL: if (D2B'(sq[0] + sq[1] + sq[2]) > best) win <= axis;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rbs_pkg::ST_SEED: begin
        for (int i = 0; i < 3; i++) begin
          c[i] <= ((CB+2)'(signed'(ext[{win, 1'b0}][i*CB +: CB]))
                 + (CB+2)'(signed'(ext[{win, 1'b1}][i*CB +: CB]))) >>> 1;
        end
        idx <= '0;
      end
      rbs_pkg::ST_SEEDSQ: if (sdone) r <= root >> 1;
      rbs_pkg::ST_RD: idx <= idx + 1'b1;
      rbs_pkg::ST_DIST: d2 <= D2B'(sq[0] + sq[1] + sq[2]);
      rbs_pkg::ST_SQRT: if (sdone) begin
        dval <= root;
        k <= 2'd0;
      end
      rbs_pkg::ST_GROW: if (ddone) begin
        if (!diff[k][CB+1]) c[k] <= c[k] + (CB+2)'(quot);
        else c[k] <= c[k] - (CB+2)'(quot) - (CB+2)'(rem_nz);
        k <= k + 1'b1;
        if (k == 2'd2) r <= SQB'(({1'b0, r} + {1'b0, dval}) >> 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rbs_pkg::ST_OUT) begin
      for (int i = 0; i < 3; i++) begin
        if (c[i] > (CB+2)'(2**(CB-1) - 1)) obuf[i*CB +: CB] <= {1'b0, {(CB-1){1'b1}}};
        else if (c[i] < -(CB+2)'(2**(CB-1))) obuf[i*CB +: CB] <= {1'b1, {(CB-1){1'b0}}};
        else obuf[i*CB +: CB] <= c[i][CB-1:0];
      end
      obuf[3*CB +: CB+1] <= (r > SQB'(2**(CB+1) - 1)) ? {(CB+1){1'b1}} : (CB+1)'(r);
      obuf[4*CB+1] <= drop;
      obuf[103:4*CB+2] <= '0;
    end
  end

  assign m_tdata = obuf;
  assign m_tlast = 1'b1;

  `RBS_ASSERT_IMP(a_no_load_busy, m_tvalid, !s_tready, "input taken with result pending")
  `RBS_ASSERT_NXT(a_out_valid, state == rbs_pkg::ST_OUT, m_tvalid, "result not raised")
  `RBS_ASSERT_IMP(a_count_bound, 1'b1, count <= NB'(rbs_pkg::MAX_POINTS), "count beyond depth")
endmodule
